>>> sv/wavetable_morph_reader_defines.svh
// assertion macros for the wavetable morph reader checker
`ifndef WAVETABLE_MORPH_READER_DEFINES_SVH
`define WAVETABLE_MORPH_READER_DEFINES_SVH

// implication checked while out of reset
`define WMR_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication checked at every edge, reset included
`define WMR_ASSERT_ALWAYS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

>>> sv/wmr_pkg.sv
// shared types and constants for the wavetable morph reader
`default_nettype none

package wmr_pkg;

    localparam int FRAME_SIZE   = 2048;
    localparam int MAX_FRAMES   = 8;
    localparam int STORE_DEPTH  = FRAME_SIZE * MAX_FRAMES;
    localparam int ADDR_W       = $clog2(STORE_DEPTH);
    localparam int WCOUNT_W     = $clog2(STORE_DEPTH + 1);
    localparam int SAMPLE_IDX_W = $clog2(FRAME_SIZE);
    localparam int FRAME_IDX_W  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int FCOUNT_W     = $clog2(MAX_FRAMES + 1);
    localparam int PHASE_PROD_W = 32 + SAMPLE_IDX_W;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic       KIND_LOAD  = 1'b0;
    localparam logic       KIND_READ  = 1'b1;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    localparam logic [16:0] POS_ONE   = 17'h10000;

    typedef struct packed {
        logic               kind;
        logic signed [15:0] sample_value;
        logic [31:0]        phase;
        logic [16:0]        position;
    } wmr_item_t;

    typedef struct packed {
        logic signed [15:0] sample_out;
        logic [1:0]         status;
    } wmr_result_t;

    typedef struct packed {
        logic                    is_read;
        logic [1:0]              status;
        logic [ADDR_W-1:0]       wr_addr;
        logic signed [15:0]      wr_data;
        logic [FRAME_IDX_W-1:0]  f0;
        logic [FRAME_IDX_W-1:0]  f1;
        logic [SAMPLE_IDX_W-1:0] i0;
        logic [SAMPLE_IDX_W-1:0] i1;
        logic [15:0]             t;
        logic [15:0]             ft;
    } wmr_cmd_t;

endpackage

`default_nettype wire

>>> sv/wmr_front.sv
// front end: accepts items, tracks fill, works out frame and sample indexes
`default_nettype none

module wmr_front
    import wmr_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    input  wire wmr_item_t item,
    input  wire logic      full,
    output logic           push,
    output wmr_cmd_t       cmd
);

    localparam int P_W = 17 + FCOUNT_W;

    logic [WCOUNT_W-1:0]     write_count_reg, write_count_next;
    logic [SAMPLE_IDX_W-1:0] slot_reg, slot_next;
    logic [FCOUNT_W-1:0]     frame_count_reg, frame_count_next;

    logic                    accept;
    logic                    table_full;
    logic [16:0]             pos_clamp;
    logic [FCOUNT_W-1:0]     last;
    logic [P_W-1:0]          p;
    logic [FCOUNT_W:0]       f0_raw;
    logic                    f0_sat;
    logic [FCOUNT_W-1:0]     f0_sel;
    logic [FCOUNT_W-1:0]     f1_sel;
    logic [PHASE_PROD_W-1:0] x;
    logic [SAMPLE_IDX_W-1:0] i0;

    assign accept     = start && !full;
    assign push       = accept;
    assign table_full = (write_count_reg == WCOUNT_W'(STORE_DEPTH));

    assign pos_clamp = (item.position > POS_ONE) ? POS_ONE : item.position;
    assign last      = frame_count_reg - FCOUNT_W'(1);
    assign p         = P_W'(pos_clamp) * P_W'(last);
    assign f0_raw    = p[P_W-1:16];
    assign f0_sat    = (f0_raw >= {1'b0, last});
    assign f0_sel    = f0_sat ? last : f0_raw[FCOUNT_W-1:0];
    assign f1_sel    = (f0_sel < last) ? f0_sel + FCOUNT_W'(1) : last;

    assign x  = PHASE_PROD_W'(item.phase) * PHASE_PROD_W'(FRAME_SIZE);
    assign i0 = x[PHASE_PROD_W-1:32];

    always_comb
    begin
        cmd.is_read = (item.kind == KIND_READ);
        cmd.wr_addr = write_count_reg[ADDR_W-1:0];
        cmd.wr_data = item.sample_value;
        cmd.f0      = f0_sel[FRAME_IDX_W-1:0];
        cmd.f1      = f1_sel[FRAME_IDX_W-1:0];
        cmd.i0      = i0;
        cmd.i1      = (i0 == SAMPLE_IDX_W'(FRAME_SIZE - 1)) ? '0 : i0 + SAMPLE_IDX_W'(1);
        cmd.t       = x[31:16];
        cmd.ft      = f0_sat ? 16'd0 : p[15:0];
        if (item.kind == KIND_LOAD)
        begin
            cmd.status = table_full ? STAT_FULL : STAT_OK;
        end
        else
        begin
            cmd.status = (frame_count_reg == '0) ? STAT_EMPTY : STAT_OK;
        end
    end

    always_comb
    begin
        write_count_next = write_count_reg;
        slot_next        = slot_reg;
        frame_count_next = frame_count_reg;
        if (accept && item.kind == KIND_LOAD && !table_full)
        begin
            write_count_next = write_count_reg + WCOUNT_W'(1);
            if (slot_reg == SAMPLE_IDX_W'(FRAME_SIZE - 1))
            begin
                slot_next        = '0;
                frame_count_next = frame_count_reg + FCOUNT_W'(1);
            end
            else
            begin
                slot_next = slot_reg + SAMPLE_IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_count_reg <= '0;
            slot_reg        <= '0;
            frame_count_reg <= '0;
        end
        else
        begin
            write_count_reg <= write_count_next;
            slot_reg        <= slot_next;
            frame_count_reg <= frame_count_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/wmr_queue.sv
// short command queue between front and back
`default_nettype none

module wmr_queue
    import wmr_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire wmr_cmd_t push_data,
    input  wire logic     pop,
    output wmr_cmd_t      head,
    output logic          not_empty,
    output logic          full
);

    wmr_cmd_t          entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head      = entries_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + QPTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

>>> sv/wmr_back.sv
// back end: sample store, four reads per lookup and shared interpolator
`default_nettype none

module wmr_back
    import wmr_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     cmd_valid,
    input  wire wmr_cmd_t cmd,
    output logic          pop,
    output logic          done,
    output wmr_result_t   result
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_R1   = 3'd1;
    localparam logic [2:0] S_R2   = 3'd2;
    localparam logic [2:0] S_R3   = 3'd3;
    localparam logic [2:0] S_R4   = 3'd4;
    localparam logic [2:0] S_R5   = 3'd5;

    function automatic logic [ADDR_W-1:0] frame_addr(
        input logic [FRAME_IDX_W-1:0]  f,
        input logic [SAMPLE_IDX_W-1:0] i
    );
        return ADDR_W'(f) * ADDR_W'(FRAME_SIZE) + ADDR_W'(i);
    endfunction

    logic signed [15:0] sample_store [STORE_DEPTH];

    logic [2:0]         state_reg, state_next;
    logic               done_reg, done_next;
    wmr_result_t        result_reg, result_next;
    wmr_cmd_t           cmd_reg;
    logic signed [15:0] rd_data_reg;
    logic signed [15:0] s0_reg;
    logic signed [15:0] a_reg;
    logic signed [15:0] b_reg;

    logic               mem_we;
    logic [ADDR_W-1:0]  raddr;
    logic signed [15:0] lerp_a;
    logic signed [15:0] lerp_b;
    logic [15:0]        lerp_t;
    logic signed [16:0] lerp_diff;
    logic signed [33:0] lerp_prod;
    logic signed [33:0] lerp_sum;
    logic signed [15:0] lerp_y;

    assign pop    = (state_reg == S_IDLE) && cmd_valid;
    assign mem_we = pop && !cmd.is_read && (cmd.status == STAT_OK);
    assign done   = done_reg;
    assign result = result_reg;

    always_comb
    begin
        unique case (state_reg)
            S_IDLE:  raddr = frame_addr(cmd.f0, cmd.i0);
            S_R1:    raddr = frame_addr(cmd_reg.f0, cmd_reg.i1);
            S_R2:    raddr = frame_addr(cmd_reg.f1, cmd_reg.i0);
            S_R3:    raddr = frame_addr(cmd_reg.f1, cmd_reg.i1);
            default: raddr = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            sample_store[cmd.wr_addr] <= cmd.wr_data;
        end
        rd_data_reg <= sample_store[raddr];
    end

    // floor interpolation shared by both frames and the morph step
    always_comb
    begin
        if (state_reg == S_R5)
        begin
            lerp_a = a_reg;
            lerp_b = b_reg;
            lerp_t = cmd_reg.ft;
        end
        else
        begin
            lerp_a = s0_reg;
            lerp_b = rd_data_reg;
            lerp_t = cmd_reg.t;
        end
        lerp_diff = 17'(lerp_b) - 17'(lerp_a);
        lerp_prod = 34'(lerp_diff) * $signed({18'd0, lerp_t});
        lerp_sum  = 34'(lerp_a) + (lerp_prod >>> 16);
        lerp_y    = lerp_sum[15:0];
    end

    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.is_read && cmd.status == STAT_OK)
                    begin
                        state_next = S_R1;
                    end
                    else
                    begin
                        done_next              = 1'b1;
                        result_next.sample_out = '0;
                        result_next.status     = cmd.status;
                    end
                end
            end
            S_R1: state_next = S_R2;
            S_R2: state_next = S_R3;
            S_R3: state_next = S_R4;
            S_R4: state_next = S_R5;
            S_R5:
            begin
                state_next             = S_IDLE;
                done_next              = 1'b1;
                result_next.sample_out = lerp_y;
                result_next.status     = STAT_OK;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        if (pop)
        begin
            cmd_reg <= cmd;
        end
        if (state_reg == S_R1 || state_reg == S_R3)
        begin
            s0_reg <= rd_data_reg;
        end
        if (state_reg == S_R2)
        begin
            a_reg <= lerp_y;
        end
        if (state_reg == S_R4)
        begin
            b_reg <= lerp_y;
        end
    end

endmodule

`default_nettype wire

>>> sv/wavetable_morph_reader.sv
// top level of the wavetable morph reader
//
// Items come in on item, taken at a rising edge where start is high and busy
// is low. An item either appends one Q2.14 sample to the frame store or asks
// for an interpolated sample at a Q0.32 phase and a Q1.16 morph position.
// Every item gives one result on result, shown for exactly one cycle with
// done high; the receiver cannot stall it.
// A front end classifies items and works out indexes into a two-entry queue;
// a back end drains the queue. busy is high while the queue is full.
// Between accept and done an item passes through the queue; for a load or a
// refused read the back end registers done from S_IDLE, for a read from S_R5.
// Loads are taken one per cycle while no read holds the back end; a read holds
// it from its pop through S_R1 to S_R5, set by the four sequential reads of the
// sample store through its single read port and the shared interpolator.
// Reset clears the fill counters, the queue and the back end state; the
// sample store is not cleared, since only complete frames are ever read.
`default_nettype none

module wavetable_morph_reader
    import wmr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire wmr_item_t   item,
    output logic             done,
    output wmr_result_t      result
);

    logic     q_push;
    logic     q_pop;
    logic     q_not_empty;
    logic     q_full;
    wmr_cmd_t front_cmd;
    wmr_cmd_t q_head;

    assign busy = q_full;

    wmr_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .item  (item),
        .full  (q_full),
        .push  (q_push),
        .cmd   (front_cmd)
    );

    wmr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (front_cmd),
        .pop       (q_pop),
        .head      (q_head),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    wmr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_not_empty),
        .cmd       (q_head),
        .pop       (q_pop),
        .done      (done),
        .result    (result)
    );

endmodule

`default_nettype wire

>>> sv/wmr_checker.sv
// port-level checker for the wavetable morph reader and its bind
`default_nettype none

`include "wavetable_morph_reader_defines.svh"

module wmr_checker
    import wmr_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        busy,
    input wire logic        done,
    input wire wmr_result_t result
);

    `WMR_ASSERT_IMPL(a_refused_is_zero, done && result.status != STAT_OK, result.sample_out == 16'sd0, "refused item with nonzero sample")
    `WMR_ASSERT_IMPL(a_status_code, done, result.status == STAT_OK || result.status == STAT_FULL || result.status == STAT_EMPTY, "unknown status code")
    `WMR_ASSERT_ALWAYS(a_reset_quiet, $rose(rst_n), !done && !busy, "outputs active right after reset")

endmodule

bind wavetable_morph_reader wmr_checker u_wmr_checker (.*);

`default_nettype wire

>>> test/wavetable_morph_reader_tb.sv
// self-checking testbench for the wavetable morph reader: empty reads and partial frame fill
`timescale 1ns / 1ps

module wavetable_morph_reader_tb;
    import wmr_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 20;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    wmr_item_t   item = '0;
    logic        done;
    wmr_result_t result;

    wmr_item_t   pending_items[$];
    wmr_result_t expected_results[$];
    wmr_result_t next_expected;

    logic signed [15:0] frame_store [STORE_DEPTH];
    int fill_count = 0;
    int frames_ready = 0;

    int idle_pct = 0;
    int fail_count = 0;
    int cycle_count = 0;
    int idle_plan [4] = '{0, 77, 0, 8};

    wavetable_morph_reader DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint lerp_q16(longint a, longint b, int t);
        return a + (((b - a) * longint'(t)) >>> 16);
    endfunction

    function automatic longint frame_value(int f, logic [31:0] ph);
        bit [63:0] x;
        int i0;
        int i1;
        int base;
        x = 64'(ph) * 64'(FRAME_SIZE);
        i0 = int'(x >> 32);
        i1 = (i0 + 1 >= FRAME_SIZE) ? 0 : i0 + 1;
        base = f * FRAME_SIZE;
        return lerp_q16(frame_store[base + i0], frame_store[base + i1], int'(x[31:16]));
    endfunction

    task automatic predict_result(wmr_item_t it);
        wmr_result_t r;
        int last;
        int pos;
        int p;
        int f0;
        int f1;
        int ft;
        longint a;
        longint b;
        r.sample_out = '0;
        r.status = STAT_OK;
        if (it.kind == KIND_LOAD)
        begin
            if (fill_count < STORE_DEPTH)
            begin
                frame_store[fill_count] = it.sample_value;
                fill_count++;
                frames_ready = fill_count / FRAME_SIZE;
            end
            else
                r.status = STAT_FULL;
        end
        else if (frames_ready == 0)
            r.status = STAT_EMPTY;
        else
        begin
            last = frames_ready - 1;
            pos = (it.position > POS_ONE) ? int'(POS_ONE) : int'(it.position);
            p = pos * last;
            f0 = p >> 16;
            ft = p & 'hFFFF;
            if (f0 >= last)
            begin
                f0 = last;
                ft = 0;
            end
            f1 = (f0 + 1 > last) ? last : f0 + 1;
            a = frame_value(f0, it.phase);
            b = frame_value(f1, it.phase);
            r.sample_out = 16'(lerp_q16(a, b, ft));
        end
        expected_results = {expected_results, r};
    endtask

    task automatic queue_item(wmr_item_t it);
        pending_items = {pending_items, it};
    endtask

    function automatic logic signed [15:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'sh0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_phase();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return {11'h7FF, 21'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [16:0] pick_position();
        case ($urandom_range(0, 9))
            0: return 17'h00000;
            1: return POS_ONE;
            2: return 17'h1FFFF;
            3: return 17'($urandom_range(65537, 131071));
            4: return 17'($urandom);
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic wmr_item_t load_item(logic signed [15:0] value);
        wmr_item_t it;
        it.kind = KIND_LOAD;
        it.sample_value = value;
        it.phase = $urandom;
        it.position = 17'($urandom);
        return it;
    endfunction

    function automatic wmr_item_t read_item(logic [31:0] ph, logic [16:0] pos);
        wmr_item_t it;
        it.kind = KIND_READ;
        it.sample_value = 16'($urandom);
        it.phase = ph;
        it.position = pos;
        return it;
    endfunction

    task automatic drain_items();
        while (pending_items.size() != 0 || start)
            @(posedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            item <= '0;
        end
        else
        begin
            if (start && !busy)
                predict_result(item);
            if (!start || !busy)
            begin
                if (pending_items.size() != 0 && $urandom_range(0, 99) >= idle_pct)
                begin
                    start <= 1'b1;
                    item <= pending_items.pop_front();
                end
                else
                    start <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result sample_out %0d status %0d",
                         $time, result.sample_out, result.status);
                fail_count++;
            end
            else
            begin
                next_expected = expected_results.pop_front();
                if (result.sample_out !== next_expected.sample_out)
                begin
                    $display("%0t: sample_out mismatch expected %0d actual %0d",
                             $time, next_expected.sample_out, result.sample_out);
                    fail_count++;
                end
                if (result.status !== next_expected.status)
                begin
                    $display("%0t: status mismatch expected %0d actual %0d",
                             $time, next_expected.status, result.status);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("wavetable_morph_reader verification failed");
            $finish;
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // empty table, then the first samples of a frame
        idle_pct = idle_plan[0];
        queue_item(read_item(32'h0000_0000, 17'h00000));
        queue_item(read_item(32'hFFFF_FFFF, 17'h1FFFF));
        queue_item(load_item(16'sh7FFF));
        queue_item(load_item(16'sh8000));
        queue_item(read_item(32'h8000_0000, POS_ONE));
        queue_item(read_item({11'h7FF, 21'h1FFFFF}, 17'h0FFFF));
        drain_items();

        // partial frame fill with reads mixed in, one idle pattern per pass
        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct = idle_plan[ph];
            for (int k = 0; k < 170; k++)
            begin
                queue_item(load_item(pick_sample()));
                if (k % 16 == 0)
                    queue_item(read_item(pick_phase(), pick_position()));
            end
            drain_items();
        end

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("wavetable_morph_reader verification clean");
        else
            $display("wavetable_morph_reader verification failed");
        $finish;
    end

endmodule

>>> wavetable_morph_reader.f
+incdir+sv
sv/wmr_pkg.sv
sv/wmr_front.sv
sv/wmr_queue.sv
sv/wmr_back.sv
sv/wavetable_morph_reader.sv
sv/wmr_checker.sv
test/wavetable_morph_reader_tb.sv
